FILE: design/seven_segment_code_sequencer_assert.svh
// Assertion macros for the seven-segment code sequencer.
// Depends on nothing; included by seven_segment_code_sequencer, which checks its own logic.
`ifndef SEVEN_SEGMENT_CODE_SEQUENCER_ASSERT_SVH
`define SEVEN_SEGMENT_CODE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define SSCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that cons holds in the cycle after ante.
`define SSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SSCS_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SSCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: design/sscs_pkg.sv
// Shared types, phase codes, timing constants and the segment font.
// No dependencies; used by sscs_step and seven_segment_code_sequencer.
package sscs_pkg;

   // command codes on the func field
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_WORD = 2'd1;
   localparam logic [1:0] FUNC_BYTE = 2'd2;
   localparam logic [1:0] FUNC_LAMP = 2'd3;

   // sequence phases
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_WFLASH  = 4'd1;
   localparam logic [3:0] PH_WBLANK  = 4'd2;
   localparam logic [3:0] PH_WDIGIT  = 4'd3;
   localparam logic [3:0] PH_BBLANK1 = 4'd4;
   localparam logic [3:0] PH_BHIGH   = 4'd5;
   localparam logic [3:0] PH_BBLANK2 = 4'd6;
   localparam logic [3:0] PH_BLOW    = 4'd7;
   localparam logic [3:0] PH_LOFF1   = 4'd8;
   localparam logic [3:0] PH_LON     = 4'd9;
   localparam logic [3:0] PH_LOFF2   = 4'd10;
   localparam logic [3:0] PH_LWALK   = 4'd11;

   // register indexes on the csr port
   localparam logic [2:0] CSR_ACTIVE_LOW    = 3'd0;
   localparam logic [2:0] CSR_REVERSE_BITS  = 3'd1;
   localparam logic [2:0] CSR_FLASH_TOGGLES = 3'd2;
   localparam logic [2:0] CSR_FLASH_TICKS   = 3'd3;
   localparam logic [2:0] CSR_BLANK_TICKS   = 3'd4;
   localparam logic [2:0] CSR_DIGIT_TICKS   = 3'd5;

   // register reset values
   localparam logic [5:0] RST_FLASH_TOGGLES = 6'd10;
   localparam logic [7:0] RST_FLASH_TICKS   = 8'd25;
   localparam logic [7:0] RST_BLANK_TICKS   = 8'd25;
   localparam logic [7:0] RST_DIGIT_TICKS   = 8'd100;

   // fixed step timing of byte and lamp test sequences
   localparam logic [7:0] TK_GAP       = 8'd10;
   localparam logic [7:0] TK_BYTE_HIGH = 8'd25;
   localparam logic [7:0] TK_BYTE_LOW  = 8'd75;
   localparam logic [7:0] TK_LAMP      = 8'd10;
   localparam logic [7:0] TK_WALK      = 8'd5;

   localparam logic [7:0] PAT_BLANK = 8'h00;
   localparam logic [7:0] PAT_DP    = 8'h80;
   localparam logic [7:0] PAT_ALL   = 8'hff;
   localparam logic [5:0] WALK_STEPS = 6'd8;

   localparam logic [7:0] SEG_FONT [16] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h67, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
   };

   typedef struct packed {
      logic       active_low;
      logic       reverse_bits;
      logic [5:0] flash_toggles;
      logic [7:0] flash_ticks;
      logic [7:0] blank_ticks;
      logic [7:0] digit_ticks;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [7:0]  ticks_left;
      logic [5:0]  step_index;
      logic [31:0] held_value;
      logic        held_fatal;
      logic        held_last;
      logic [7:0]  pattern;
   } state_type;

   // zero duration counts as one tick
   function automatic logic [7:0] dur(input logic [7:0] t);
      return (t == 8'd0) ? 8'd1 : t;
   endfunction

   // mirror, then invert, the pattern for the pins
   function automatic logic [7:0] drive(input logic [7:0] p, input cfg_type c);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = c.reverse_bits ? p[7 - i] : p[i];
      end
      return c.active_low ? ~r : r;
   endfunction

endpackage

FILE: design/sscs_step.sv
// Next-state logic of the sequencer for one tick or command item.
// Depends on sscs_pkg; instantiated by seven_segment_code_sequencer.
module sscs_step #(
   parameter int NIBBLES = 8
) (
   input  sscs_pkg::state_type cur,
   input  sscs_pkg::cfg_type   cfg,
   input  logic [1:0]          func,
   input  logic [31:0]         value,
   input  logic                fatal,
   input  logic                last_byte,
   output sscs_pkg::state_type nxt,
   output logic                accepted,
   output logic                done
);

   localparam logic [5:0] TOP_NIBBLE = 6'(NIBBLES - 1);

   logic [7:0] ticks_dec;
   logic [5:0] step_inc;
   logic [5:0] step_dec;
   logic [3:0] nib_sel;
   logic [3:0] nib_val;
   logic [31:0] nib_shift;

   assign ticks_dec = cur.ticks_left - {7'd0, cur.ticks_left != 8'd0};
   assign step_inc  = cur.step_index + 6'd1;
   assign step_dec  = cur.step_index - 6'd1;
   assign nib_sel   = cur.step_index[3:0];
   assign nib_shift = cur.held_value >> {nib_sel[2:0], 2'b00};
   // nibbles beyond the word read as zero
   assign nib_val   = nib_sel[3] ? 4'd0 : nib_shift[3:0];

   always_comb begin
      nxt      = cur;
      accepted = 1'b0;
      done     = 1'b0;
      if (func == sscs_pkg::FUNC_TICK) begin
         // count down and move on when the step runs out
         if (cur.phase != sscs_pkg::PH_IDLE) begin
            nxt.ticks_left = ticks_dec;
            if (ticks_dec == 8'd0) begin
               unique case (cur.phase)
                  sscs_pkg::PH_WFLASH: begin
                     if (step_inc < cfg.flash_toggles) begin
                        nxt.step_index = step_inc;
                        nxt.pattern    = cur.pattern ^ sscs_pkg::PAT_DP;
                        nxt.ticks_left = sscs_pkg::dur(cfg.flash_ticks);
                     end else begin
                        nxt.phase      = sscs_pkg::PH_WBLANK;
                        nxt.step_index = TOP_NIBBLE;
                        nxt.pattern    = sscs_pkg::PAT_BLANK;
                        nxt.ticks_left = sscs_pkg::dur(cfg.blank_ticks);
                     end
                  end
                  sscs_pkg::PH_WBLANK: begin
                     nxt.phase      = sscs_pkg::PH_WDIGIT;
                     nxt.pattern    = sscs_pkg::SEG_FONT[nib_val];
                     nxt.ticks_left = sscs_pkg::dur(cfg.digit_ticks);
                  end
                  sscs_pkg::PH_WDIGIT: begin
                     if (cur.step_index != 6'd0) begin
                        nxt.phase      = sscs_pkg::PH_WBLANK;
                        nxt.step_index = step_dec;
                        nxt.pattern    = sscs_pkg::PAT_BLANK;
                        nxt.ticks_left = sscs_pkg::dur(cfg.blank_ticks);
                     end else if (cur.held_fatal) begin
                        // restart the whole word pass
                        if (cfg.flash_toggles != 6'd0) begin
                           nxt.phase      = sscs_pkg::PH_WFLASH;
                           nxt.step_index = 6'd0;
                           nxt.pattern    = sscs_pkg::PAT_DP;
                           nxt.ticks_left = sscs_pkg::dur(cfg.flash_ticks);
                        end else begin
                           nxt.phase      = sscs_pkg::PH_WBLANK;
                           nxt.step_index = TOP_NIBBLE;
                           nxt.pattern    = sscs_pkg::PAT_BLANK;
                           nxt.ticks_left = sscs_pkg::dur(cfg.blank_ticks);
                        end
                     end else begin
                        nxt.phase = sscs_pkg::PH_IDLE;
                        done      = 1'b1;
                     end
                  end
                  sscs_pkg::PH_BBLANK1: begin
                     nxt.phase      = sscs_pkg::PH_BHIGH;
                     nxt.pattern    = sscs_pkg::SEG_FONT[cur.held_value[7:4]];
                     nxt.ticks_left = sscs_pkg::TK_BYTE_HIGH;
                  end
                  sscs_pkg::PH_BHIGH: begin
                     nxt.phase      = sscs_pkg::PH_BBLANK2;
                     nxt.pattern    = sscs_pkg::PAT_BLANK;
                     nxt.ticks_left = sscs_pkg::TK_GAP;
                  end
                  sscs_pkg::PH_BBLANK2: begin
                     nxt.phase      = sscs_pkg::PH_BLOW;
                     nxt.pattern    = sscs_pkg::SEG_FONT[cur.held_value[3:0]];
                     nxt.ticks_left = sscs_pkg::TK_BYTE_LOW;
                  end
                  sscs_pkg::PH_BLOW: begin
                     nxt.phase = sscs_pkg::PH_IDLE;
                     done      = cur.held_last;
                  end
                  sscs_pkg::PH_LOFF1: begin
                     nxt.phase      = sscs_pkg::PH_LON;
                     nxt.pattern    = sscs_pkg::PAT_ALL;
                     nxt.ticks_left = sscs_pkg::TK_LAMP;
                  end
                  sscs_pkg::PH_LON: begin
                     nxt.phase      = sscs_pkg::PH_LOFF2;
                     nxt.pattern    = sscs_pkg::PAT_BLANK;
                     nxt.ticks_left = sscs_pkg::TK_LAMP;
                  end
                  sscs_pkg::PH_LOFF2: begin
                     nxt.phase      = sscs_pkg::PH_LWALK;
                     nxt.step_index = 6'd0;
                     nxt.pattern    = 8'h01;
                     nxt.ticks_left = sscs_pkg::TK_WALK;
                  end
                  sscs_pkg::PH_LWALK: begin
                     nxt.step_index = step_inc;
                     if (step_inc < sscs_pkg::WALK_STEPS) begin
                        nxt.pattern    = 8'h01 << step_inc[2:0];
                        nxt.ticks_left = sscs_pkg::TK_WALK;
                     end else begin
                        nxt.phase   = sscs_pkg::PH_IDLE;
                        nxt.pattern = sscs_pkg::PAT_BLANK;
                        done        = 1'b1;
                     end
                  end
                  default: begin
                     nxt.phase = sscs_pkg::PH_IDLE;
                  end
               endcase
            end
         end
      end else if (cur.phase == sscs_pkg::PH_IDLE) begin
         // start a sequence; commands while busy are dropped
         accepted       = 1'b1;
         nxt.held_value = value;
         unique case (func)
            sscs_pkg::FUNC_WORD: begin
               nxt.held_fatal = fatal;
               if (cfg.flash_toggles != 6'd0) begin
                  nxt.phase      = sscs_pkg::PH_WFLASH;
                  nxt.step_index = 6'd0;
                  nxt.pattern    = sscs_pkg::PAT_DP;
                  nxt.ticks_left = sscs_pkg::dur(cfg.flash_ticks);
               end else begin
                  nxt.phase      = sscs_pkg::PH_WBLANK;
                  nxt.step_index = TOP_NIBBLE;
                  nxt.pattern    = sscs_pkg::PAT_BLANK;
                  nxt.ticks_left = sscs_pkg::dur(cfg.blank_ticks);
               end
            end
            sscs_pkg::FUNC_BYTE: begin
               nxt.held_last  = last_byte;
               nxt.phase      = sscs_pkg::PH_BBLANK1;
               nxt.pattern    = sscs_pkg::PAT_BLANK;
               nxt.ticks_left = sscs_pkg::TK_GAP;
            end
            default: begin
               nxt.phase      = sscs_pkg::PH_LOFF1;
               nxt.pattern    = sscs_pkg::PAT_BLANK;
               nxt.ticks_left = sscs_pkg::TK_LAMP;
            end
         endcase
      end
   end

endmodule

FILE: design/seven_segment_code_sequencer.sv
// Top level of the seven-segment code sequencer: state, config and result registers.
// Depends on sscs_pkg, sscs_step and seven_segment_code_sequencer_assert.svh.
//
//   channel  ports                                   direction  role
//   req      valid/ready, func, value, fatal,        in         ticks and commands
//            last_byte
//   rsp      valid/ready, segments, busy_res,        out        one result per item
//            accepted, run_complete
//   csr      wr_en, index, wdata                     in         register writes
//
// The state update is one pass of sscs_step between the state registers and the
// result register, so an item can enter every cycle unless rsp stalls. A result
// is registered and appears in the cycle after its transfer; req_ready stays high while
// the result register is empty or being taken, so a stall on rsp holds off req only.
// Synchronous reset blanks the pattern, idles the sequencer and loads register defaults.
`include "seven_segment_code_sequencer_assert.svh"

module seven_segment_code_sequencer #(
   parameter int NIBBLES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_value,
   input  logic        req_fatal,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_segments,
   output logic        rsp_busy_res,
   output logic        rsp_accepted,
   output logic        rsp_run_complete,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   sscs_pkg::cfg_type   cfg_ff;
   sscs_pkg::cfg_type   cfg_in;
   sscs_pkg::state_type state_ff;
   sscs_pkg::state_type state_in;
   logic                step_accepted;
   logic                step_done;
   logic                req_xfer;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [7:0]          rsp_segments_ff;
   logic                rsp_busy_ff;
   logic                rsp_accepted_ff;
   logic                rsp_done_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            sscs_pkg::CSR_ACTIVE_LOW:    cfg_in.active_low    = csr_wdata[0];
            sscs_pkg::CSR_REVERSE_BITS:  cfg_in.reverse_bits  = csr_wdata[0];
            sscs_pkg::CSR_FLASH_TOGGLES: cfg_in.flash_toggles = csr_wdata[5:0];
            sscs_pkg::CSR_FLASH_TICKS:   cfg_in.flash_ticks   = csr_wdata;
            sscs_pkg::CSR_BLANK_TICKS:   cfg_in.blank_ticks   = csr_wdata;
            sscs_pkg::CSR_DIGIT_TICKS:   cfg_in.digit_ticks   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low    <= 1'b0;
         cfg_ff.reverse_bits  <= 1'b0;
         cfg_ff.flash_toggles <= sscs_pkg::RST_FLASH_TOGGLES;
         cfg_ff.flash_ticks   <= sscs_pkg::RST_FLASH_TICKS;
         cfg_ff.blank_ticks   <= sscs_pkg::RST_BLANK_TICKS;
         cfg_ff.digit_ticks   <= sscs_pkg::RST_DIGIT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // next state for the offered item
   sscs_step #(
      .NIBBLES (NIBBLES)
   ) u_step (
      .cur       (state_ff),
      .cfg       (cfg_ff),
      .func      (req_func),
      .value     (req_value),
      .fatal     (req_fatal),
      .last_byte (req_last_byte),
      .nxt       (state_in),
      .accepted  (step_accepted),
      .done      (step_done)
   );

   // advance the sequencer on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= sscs_pkg::PH_IDLE;
         state_ff.ticks_left <= 8'd0;
         state_ff.step_index <= 6'd0;
         state_ff.held_value <= 32'd0;
         state_ff.held_fatal <= 1'b0;
         state_ff.held_last  <= 1'b0;
         state_ff.pattern    <= sscs_pkg::PAT_BLANK;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // result register: load on transfer, drop when taken
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_segments_ff <= sscs_pkg::drive(state_in.pattern, cfg_ff);
         rsp_busy_ff     <= state_in.phase != sscs_pkg::PH_IDLE;
         rsp_accepted_ff <= step_accepted;
         rsp_done_ff     <= step_done;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_segments     = rsp_segments_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_run_complete = rsp_done_ff;

   `SSCS_ASSERT_SAME(a_busy_has_time, clock, reset, state_ff.phase != sscs_pkg::PH_IDLE,
      state_ff.ticks_left != 8'd0, "running step has no ticks left")
   `SSCS_ASSERT_SAME(a_accept_busy, clock, reset, rsp_valid_ff && rsp_accepted_ff,
      rsp_busy_ff, "accepted command left sequencer idle")
   `SSCS_ASSERT_SAME(a_done_idle, clock, reset, rsp_valid_ff && rsp_done_ff,
      !rsp_busy_ff && !rsp_accepted_ff, "completed run still busy or accepted")
   `SSCS_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_ready,
      !req_ready, "input taken while result stalled")
   `SSCS_ASSERT_NEXT(a_idle_hold, clock, reset,
      req_xfer && state_ff.phase == sscs_pkg::PH_IDLE && req_func == sscs_pkg::FUNC_TICK,
      state_ff.phase == sscs_pkg::PH_IDLE, "tick moved an idle sequencer")

endmodule
